// ----- rtl/core/frt_pkg.sv -----
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants for the fault record table: table geometry,
// command and register codes, and the request, configuration, control and result structs.
// ----------------------------------------------------------------------------
package frt_pkg;

	// table geometry
	localparam int SLOTS      = 16;
	localparam int CODE_BITS  = 8;
	localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);

	// command codes carried on the input request
	typedef enum logic [1:0] {
		CMD_REPORT    = 2'd0,
		CMD_CLEAR     = 2'd1,
		CMD_CLEAR_ALL = 2'd2,
		CMD_TICK      = 2'd3
	} cmd_code_t;

	// configuration register indexes
	localparam logic [1:0] CFG_AUTO_EN  = 2'd0;
	localparam logic [1:0] CFG_INTERVAL = 2'd1;
	localparam logic [1:0] CFG_MAX_ATT  = 2'd2;

	// one input request
	typedef struct packed {
		cmd_code_t   command;
		logic [7:0]  fault_code;
		logic [31:0] now_ms;
	} frt_item_t;

	// live configuration
	typedef struct packed {
		logic        auto_en;
		logic [15:0] interval;
		logic [7:0]  max_att;
	} frt_cfg_t;

	// controller commands to the datapath
	typedef struct packed {
		logic                  load;
		logic                  scan;
		logic                  update;
		logic [SLOT_IDX_W-1:0] idx;
	} frt_ctl_t;

	// one result, packed so that the last field lands in the lowest bits
	typedef struct packed {
		logic        report_dropped;
		logic        recovery_ok;
		logic        recovery_tried;
		logic [31:0] total_reports;
		logic [7:0]  first_active_code;
		logic [31:0] code_occurrences;
		logic        code_active;
		logic        healthy;
		logic [4:0]  active_faults;
	} frt_res_t;

endpackage

// ----- rtl/core/frt_ctrl.sv -----
// ----------------------------------------------------------------------------
// frt_ctrl
// Sequencer: takes a request, walks the slot scan, then fires the table
// update once the output register can take the result.
// ----------------------------------------------------------------------------
module frt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_free,
	output logic             in_ready,
	output frt_pkg::frt_ctl_t ctl
);
	import frt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t                state_q;
	logic [SLOT_IDX_W-1:0] idx_q;
	logic                  in_ready_q;
	logic                  scan_last;

	assign scan_last = (idx_q == SLOT_IDX_W'(SLOTS - 1));

	// command decode
	assign in_ready   = in_ready_q;
	assign ctl.load   = in_valid && in_ready_q;
	assign ctl.scan   = (state_q == ST_SCAN);
	assign ctl.update = (state_q == ST_UPDATE) && out_free;
	assign ctl.idx    = idx_q;

	// state, scan index and ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_SCAN;
						idx_q      <= '0;
						in_ready_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + SLOT_IDX_W'(1);
					if (scan_last) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// a request reaches the update step right after a full scan
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> ##(SLOTS + 1) state_q == ST_UPDATE)
		else $error("scan length wrong");
`endif

endmodule

// ----- rtl/core/frt_datapath.sv -----
// ----------------------------------------------------------------------------
// frt_datapath
// Slot table, scan trackers and the update step. The scan visits one slot
// per cycle and notes the matching slot, the first free slot and the two
// lowest active slots; the update step applies the command and forms the
// result from those notes.
// ----------------------------------------------------------------------------
module frt_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  frt_pkg::frt_ctl_t  ctl,
	input  frt_pkg::frt_item_t item,
	input  frt_pkg::frt_cfg_t  cfg,
	output frt_pkg::frt_res_t  res
);
	import frt_pkg::*;

	// captured request
	frt_item_t item_q;

	// slot table
	logic [CODE_BITS-1:0] code_q [SLOTS];
	logic [31:0]          occ_q  [SLOTS];
	logic [7:0]           att_q  [SLOTS];
	logic [SLOTS-1:0]     act_q;
	logic [CNT_W-1:0]     active_total_q;
	logic [31:0]          report_total_q;
	logic [31:0]          last_rec_q;

	// scan trackers
	logic                  m_found_q;
	logic [SLOT_IDX_W-1:0] m_idx_q;
	logic                  m_act_q;
	logic [31:0]           m_occ_q;
	logic                  f_found_q;
	logic [SLOT_IDX_W-1:0] f_idx_q;
	logic                  a1_found_q;
	logic [SLOT_IDX_W-1:0] a1_idx_q;
	logic [CODE_BITS-1:0]  a1_code_q;
	logic [7:0]            a1_att_q;
	logic                  a2_found_q;
	logic [CODE_BITS-1:0]  a2_code_q;

	// update-step values
	logic [CODE_BITS-1:0]  code_w;
	logic                  code_nz;
	logic [CODE_BITS-1:0]  rd_code;
	logic [31:0]           new_occ;
	logic [31:0]           rpt_next;
	logic [CNT_W-1:0]      cnt_next;
	logic [CODE_BITS-1:0]  first_code;
	logic                  elapsed_ok;
	logic                  tried;
	logic                  ok;
	logic                  dropped;
	logic                  c_act;
	logic [31:0]           c_occ;

	assign code_w  = CODE_BITS'(item_q.fault_code);
	assign code_nz = |code_w;
	assign rd_code = code_q[ctl.idx];

	// request capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= item;
		end
	end

	// scan trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_found_q  <= 1'b0;
			m_idx_q    <= '0;
			m_act_q    <= 1'b0;
			m_occ_q    <= '0;
			f_found_q  <= 1'b0;
			f_idx_q    <= '0;
			a1_found_q <= 1'b0;
			a1_idx_q   <= '0;
			a1_code_q  <= '0;
			a1_att_q   <= '0;
			a2_found_q <= 1'b0;
			a2_code_q  <= '0;
		end else if (ctl.load) begin
			m_found_q  <= 1'b0;
			f_found_q  <= 1'b0;
			a1_found_q <= 1'b0;
			a2_found_q <= 1'b0;
		end else if (ctl.scan) begin
			if (!m_found_q && rd_code == code_w) begin
				m_found_q <= 1'b1;
				m_idx_q   <= ctl.idx;
				m_act_q   <= act_q[ctl.idx];
				m_occ_q   <= occ_q[ctl.idx];
			end
			if (!f_found_q && rd_code == '0) begin
				f_found_q <= 1'b1;
				f_idx_q   <= ctl.idx;
			end
			if (act_q[ctl.idx]) begin
				if (!a1_found_q) begin
					a1_found_q <= 1'b1;
					a1_idx_q   <= ctl.idx;
					a1_code_q  <= rd_code;
					a1_att_q   <= att_q[ctl.idx];
				end else if (!a2_found_q) begin
					a2_found_q <= 1'b1;
					a2_code_q  <= rd_code;
				end
			end
		end
	end

	// command evaluation from the scan notes
	always_comb begin
		new_occ    = (&m_occ_q) ? m_occ_q : m_occ_q + 32'd1;
		rpt_next   = report_total_q;
		cnt_next   = active_total_q;
		first_code = a1_found_q ? a1_code_q : '0;
		elapsed_ok = (item_q.now_ms - last_rec_q) >= 32'(cfg.interval);
		tried      = 1'b0;
		ok         = 1'b0;
		dropped    = 1'b0;
		c_act      = 1'b0;
		c_occ      = '0;
		case (item_q.command)
			CMD_REPORT: begin
				if (code_nz) begin
					rpt_next = (&report_total_q) ? report_total_q : report_total_q + 32'd1;
					if (m_found_q) begin
						c_act = 1'b1;
						c_occ = new_occ;
						if (!m_act_q) begin
							cnt_next = active_total_q + CNT_W'(1);
						end
						if (!a1_found_q || m_idx_q < a1_idx_q) begin
							first_code = code_w;
						end
					end else if (f_found_q) begin
						c_act    = 1'b1;
						c_occ    = 32'd1;
						cnt_next = active_total_q + CNT_W'(1);
						if (!a1_found_q || f_idx_q < a1_idx_q) begin
							first_code = code_w;
						end
					end else begin
						dropped = 1'b1;
					end
				end
			end
			CMD_CLEAR: begin
				if (code_nz && m_found_q) begin
					c_occ = m_occ_q;
					if (m_act_q) begin
						cnt_next = active_total_q - CNT_W'(1);
					end
					// clearing the lowest active slot exposes the next one
					if (a1_found_q && a1_idx_q == m_idx_q) begin
						first_code = a2_found_q ? a2_code_q : '0;
					end
				end
			end
			CMD_CLEAR_ALL: begin
				cnt_next   = '0;
				first_code = '0;
			end
			CMD_TICK: begin
				tried = cfg.auto_en && a1_found_q && elapsed_ok;
				ok    = tried && (a1_att_q < cfg.max_att);
				if (code_nz && m_found_q) begin
					c_act = m_act_q;
					c_occ = m_occ_q;
				end
			end
			default: begin
			end
		endcase
	end

	// table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				code_q[i] <= '0;
				occ_q[i]  <= '0;
				att_q[i]  <= '0;
			end
			act_q          <= '0;
			active_total_q <= '0;
			report_total_q <= '0;
			last_rec_q     <= '0;
		end else if (ctl.update) begin
			active_total_q <= cnt_next;
			report_total_q <= rpt_next;
			case (item_q.command)
				CMD_REPORT: begin
					if (code_nz) begin
						if (m_found_q) begin
							occ_q[m_idx_q] <= new_occ;
							act_q[m_idx_q] <= 1'b1;
						end else if (f_found_q) begin
							code_q[f_idx_q] <= code_w;
							occ_q[f_idx_q]  <= 32'd1;
							att_q[f_idx_q]  <= '0;
							act_q[f_idx_q]  <= 1'b1;
						end
					end
				end
				CMD_CLEAR: begin
					if (code_nz && m_found_q) begin
						act_q[m_idx_q] <= 1'b0;
					end
				end
				CMD_CLEAR_ALL: begin
					for (int i = 0; i < SLOTS; i++) begin
						code_q[i] <= '0;
						occ_q[i]  <= '0;
						att_q[i]  <= '0;
					end
					act_q <= '0;
				end
				CMD_TICK: begin
					if (ok) begin
						att_q[a1_idx_q] <= a1_att_q + 8'd1;
					end
					if (tried) begin
						last_rec_q <= item_q.now_ms;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result
	assign res.report_dropped    = dropped;
	assign res.recovery_ok       = ok;
	assign res.recovery_tried    = tried;
	assign res.total_reports     = rpt_next;
	assign res.first_active_code = 8'(first_code);
	assign res.code_occurrences  = c_occ;
	assign res.code_active       = c_act;
	assign res.healthy           = (cnt_next == '0);
	assign res.active_faults     = (32'(cnt_next) > 32'd31) ? 5'd31 : 5'(cnt_next);

`ifndef NO_ASSERTIONS
	// the running active count tracks the active marks
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		active_total_q == CNT_W'($countones(act_q)))
		else $error("active count out of step with active marks");

	// clear-all leaves no active slot
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.update && item_q.command == CMD_CLEAR_ALL) |=> (act_q == '0))
		else $error("clear-all left an active slot");
`endif

endmodule

// ----- rtl/core/fault_record_table_top.sv -----
// ----------------------------------------------------------------------------
// fault_record_table_top
// Fault record table: stream input of commands, stream output of one
// status result per command, and a small register write port.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per command: tuser holds the command (report,
//   clear, clear all, tick), tdata the fault code and the current time.
//   m_axis returns exactly one result per request, in order.
//   cfg_* writes the recovery enable (0), the minimum recovery interval in
//   ms (1) and the per-fault attempt limit (2); other indexes are ignored.
//   cfg_ready is always high; write only while no request is in flight.
// Timing:
//   A request is taken, then the slot table is scanned one slot per cycle,
//   all SLOTS slots (16 here), then the update step loads the output register.
//   s_axis_tready stays low from taking a request until its update step, so
//   a new request is not taken before the last one is through.
//   If m_axis stalls, the result waits in the output register and the next
//   request is still taken and scanned; its update waits for the register.
// Reset:
//   arst_n clears the whole table, the counters and the output valid at once
//   and loads the register defaults; the block takes requests right after.
// ----------------------------------------------------------------------------
module fault_record_table_top (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // fault_code[7:0], now_ms[39:8]
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // active_faults[4:0], healthy[5],
	                                   // code_active[6], code_occurrences[38:7],
	                                   // first_active_code[46:39],
	                                   // total_reports[78:47], recovery_tried[79],
	                                   // recovery_ok[80], report_dropped[81]
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import frt_pkg::*;

	frt_cfg_t  cfg_q;
	frt_item_t item;
	frt_ctl_t  ctl;
	frt_res_t  res;
	frt_res_t  res_q;
	logic      m_valid_q;
	logic      out_free;

	assign item.command    = cmd_code_t'(s_axis_tuser);
	assign item.fault_code = s_axis_tdata[7:0];
	assign item.now_ms     = s_axis_tdata[39:8];

	// register writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_en  <= 1'b1;
			cfg_q.interval <= 16'd1000;
			cfg_q.max_att  <= 8'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_AUTO_EN:  cfg_q.auto_en  <= cfg_data[0];
				CFG_INTERVAL: cfg_q.interval <= cfg_data;
				CFG_MAX_ATT:  cfg_q.max_att  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	frt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_free (out_free),
		.in_ready (s_axis_tready),
		.ctl      (ctl)
	);

	frt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item),
		.cfg    (cfg_q),
		.res    (res)
	);

	// output register
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.update) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, res_q};

`ifndef NO_ASSERTIONS
	// an update always produces a result
	a_upd_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.update |=> m_valid_q)
		else $error("update without result");

	// a pending result is never overwritten
	a_no_ovr: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.update && m_valid_q) |-> m_axis_tready)
		else $error("pending result overwritten");
`endif

endmodule
